[rtl/tcat_pkg.sv]
// shared types and constants for the trajectory circle approach test
`timescale 1ns / 1ps
package tcat_pkg;

   localparam int COORD_BITS_DEF = 24;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTER_X = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTER_Y = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RADIUS   = 2'd2;

   typedef struct packed {
      logic valid;
      logic nonzero;
   } tcat_ctl_type;

endpackage

[rtl/tcat_front.sv]
// front end: differences, products and sums ahead of the cell row
`timescale 1ns / 1ps
module tcat_front #(
   parameter int COORD_BITS = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [COORD_BITS-1:0]       start_x,
   input  logic [COORD_BITS-1:0]       start_y,
   input  logic [COORD_BITS-1:0]       end_x,
   input  logic [COORD_BITS-1:0]       end_y,
   input  logic [COORD_BITS-1:0]       center_x,
   input  logic [COORD_BITS-1:0]       center_y,
   input  logic [COORD_BITS-1:0]       radius,
   output tcat_pkg::tcat_ctl_type      ctl_o,
   output logic [2*COORD_BITS+1:0]     cross_o,
   output logic [2*COORD_BITS+1:0]     len2_o,
   output logic [2*COORD_BITS+1:0]     rr_o,
   output logic [2*COORD_BITS+1:0]     se_o,
   output logic [2*COORD_BITS+1:0]     ss_o
);
   import tcat_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int XW = 2 * C + 2;

   // stage a: differences
   tcat_ctl_type        a_ctl_ff, a_ctl_in;
   logic signed [C:0]   dx_ff, dy_ff, ux_ff, uy_ff, ex_ff, ey_ff;
   logic signed [C:0]   dx_in, dy_in, ux_in, uy_in, ex_in, ey_in;
   // stage b: products
   tcat_ctl_type        b_ctl_ff, b_ctl_in;
   logic signed [XW-1:0] p_ff, q_ff, p_in, q_in;
   logic [2*C:0]        dx2_ff, dy2_ff, ex2_ff, ey2_ff, ux2_ff, uy2_ff;
   logic [2*C:0]        dx2_in, dy2_in, ex2_in, ey2_in, ux2_in, uy2_in;
   logic [2*C-1:0]      rr_ff, rr_in;
   logic signed [XW-1:0] dx2_w, dy2_w, ex2_w, ey2_w, ux2_w, uy2_w;
   // stage c: sums
   tcat_ctl_type        c_ctl_ff;
   logic [XW-1:0]       cross_ff, len2_ff, rrc_ff, se_ff, ss_ff;
   logic [XW-1:0]       cross_in, len2_in, rrc_in, se_in, ss_in;
   logic signed [XW:0]  pq;

   always_comb begin
      dx_in = $signed({end_x[C-1], end_x}) - $signed({start_x[C-1], start_x});
      dy_in = $signed({end_y[C-1], end_y}) - $signed({start_y[C-1], start_y});
      ux_in = $signed({center_x[C-1], center_x}) - $signed({start_x[C-1], start_x});
      uy_in = $signed({center_y[C-1], center_y}) - $signed({start_y[C-1], start_y});
      ex_in = $signed({center_x[C-1], center_x}) - $signed({end_x[C-1], end_x});
      ey_in = $signed({center_y[C-1], center_y}) - $signed({end_y[C-1], end_y});
      a_ctl_in.valid   = in_valid;
      a_ctl_in.nonzero = 1'b0;
   end

   always_comb begin
      p_in  = dx_ff * uy_ff;
      q_in  = dy_ff * ux_ff;
      dx2_w = dx_ff * dx_ff;
      dy2_w = dy_ff * dy_ff;
      ex2_w = ex_ff * ex_ff;
      ey2_w = ey_ff * ey_ff;
      ux2_w = ux_ff * ux_ff;
      uy2_w = uy_ff * uy_ff;
      dx2_in = dx2_w[2*C:0];
      dy2_in = dy2_w[2*C:0];
      ex2_in = ex2_w[2*C:0];
      ey2_in = ey2_w[2*C:0];
      ux2_in = ux2_w[2*C:0];
      uy2_in = uy2_w[2*C:0];
      rr_in  = radius * radius;
      b_ctl_in.valid   = a_ctl_ff.valid;
      b_ctl_in.nonzero = (dx_ff != '0) || (dy_ff != '0);
   end

   always_comb begin
      pq       = $signed({p_ff[XW-1], p_ff}) - $signed({q_ff[XW-1], q_ff});
      cross_in = pq[XW] ? XW'(-pq) : pq[XW-1:0];
      len2_in  = {1'b0, dx2_ff} + {1'b0, dy2_ff};
      se_in    = {1'b0, ex2_ff} + {1'b0, ey2_ff};
      ss_in    = {1'b0, ux2_ff} + {1'b0, uy2_ff};
      rrc_in   = {2'b00, rr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
         b_ctl_ff <= '0;
         c_ctl_ff <= '0;
      end else if (en) begin
         a_ctl_ff <= a_ctl_in;
         b_ctl_ff <= b_ctl_in;
         c_ctl_ff <= b_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         ux_ff <= ux_in;
         uy_ff <= uy_in;
         ex_ff <= ex_in;
         ey_ff <= ey_in;
         p_ff <= p_in;
         q_ff <= q_in;
         dx2_ff <= dx2_in;
         dy2_ff <= dy2_in;
         ex2_ff <= ex2_in;
         ey2_ff <= ey2_in;
         ux2_ff <= ux2_in;
         uy2_ff <= uy2_in;
         rr_ff <= rr_in;
         cross_ff <= cross_in;
         len2_ff <= len2_in;
         rrc_ff <= rrc_in;
         se_ff <= se_in;
         ss_ff <= ss_in;
      end
   end

   assign ctl_o   = c_ctl_ff;
   assign cross_o = cross_ff;
   assign len2_o  = len2_ff;
   assign rr_o    = rrc_ff;
   assign se_o    = se_ff;
   assign ss_o    = ss_ff;

endmodule

[rtl/tcat_cell.sv]
// one cell: a shift-add bit of both products and, in the first COORD_BITS+1 cells, one root bit of both distances
`timescale 1ns / 1ps
module tcat_cell #(
   parameter int COORD_BITS = 24,
   parameter int IDX        = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  tcat_pkg::tcat_ctl_type    ctl_i,
   input  logic [2*COORD_BITS+1:0]   cross_i,
   input  logic [2*COORD_BITS+1:0]   rr_i,
   input  logic [2*COORD_BITS+1:0]   len2_i,
   input  logic [4*COORD_BITS+3:0]   acc_c_i,
   input  logic [4*COORD_BITS+3:0]   acc_r_i,
   input  logic [2*COORD_BITS+1:0]   rem_e_i,
   input  logic [2*COORD_BITS+1:0]   root_e_i,
   input  logic [2*COORD_BITS+1:0]   rem_s_i,
   input  logic [2*COORD_BITS+1:0]   root_s_i,
   output tcat_pkg::tcat_ctl_type    ctl_o,
   output logic [2*COORD_BITS+1:0]   cross_o,
   output logic [2*COORD_BITS+1:0]   rr_o,
   output logic [2*COORD_BITS+1:0]   len2_o,
   output logic [4*COORD_BITS+3:0]   acc_c_o,
   output logic [4*COORD_BITS+3:0]   acc_r_o,
   output logic [2*COORD_BITS+1:0]   rem_e_o,
   output logic [2*COORD_BITS+1:0]   root_e_o,
   output logic [2*COORD_BITS+1:0]   rem_s_o,
   output logic [2*COORD_BITS+1:0]   root_s_o
);
   import tcat_pkg::*;

   localparam int XW = 2 * COORD_BITS + 2;
   localparam int AW = 2 * XW;
   localparam int R  = COORD_BITS + 1;

   tcat_ctl_type  ctl_ff;
   logic [XW-1:0] cross_ff, rr_ff, len2_ff;
   logic [AW-1:0] acc_c_ff, acc_r_ff, acc_c_in, acc_r_in;
   logic [XW-1:0] rem_e_ff, root_e_ff, rem_s_ff, root_s_ff;
   logic [XW-1:0] rem_e_in, root_e_in, rem_s_in, root_s_in;

   always_comb begin
      acc_c_in = cross_i[IDX] ? acc_c_i + (AW'(cross_i) << IDX) : acc_c_i;
      acc_r_in = rr_i[IDX] ? acc_r_i + (AW'(len2_i) << IDX) : acc_r_i;
   end

   generate
      if (IDX < R) begin : g_root
         localparam int SH = 2 * (R - 1 - IDX);
         localparam logic [XW:0] BIT = {{XW{1'b0}}, 1'b1} << SH;
         logic [XW:0] trial_e, trial_s;
         always_comb begin
            trial_e = {1'b0, root_e_i} + BIT;
            trial_s = {1'b0, root_s_i} + BIT;
            if ({1'b0, rem_e_i} >= trial_e) begin
               rem_e_in  = rem_e_i - trial_e[XW-1:0];
               root_e_in = (root_e_i >> 1) + BIT[XW-1:0];
            end else begin
               rem_e_in  = rem_e_i;
               root_e_in = root_e_i >> 1;
            end
            if ({1'b0, rem_s_i} >= trial_s) begin
               rem_s_in  = rem_s_i - trial_s[XW-1:0];
               root_s_in = (root_s_i >> 1) + BIT[XW-1:0];
            end else begin
               rem_s_in  = rem_s_i;
               root_s_in = root_s_i >> 1;
            end
         end
      end else begin : g_pass
         always_comb begin
            rem_e_in  = rem_e_i;
            root_e_in = root_e_i;
            rem_s_in  = rem_s_i;
            root_s_in = root_s_i;
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cross_ff  <= cross_i;
         rr_ff     <= rr_i;
         len2_ff   <= len2_i;
         acc_c_ff  <= acc_c_in;
         acc_r_ff  <= acc_r_in;
         rem_e_ff  <= rem_e_in;
         root_e_ff <= root_e_in;
         rem_s_ff  <= rem_s_in;
         root_s_ff <= root_s_in;
      end
   end

   assign ctl_o    = ctl_ff;
   assign cross_o  = cross_ff;
   assign rr_o     = rr_ff;
   assign len2_o   = len2_ff;
   assign acc_c_o  = acc_c_ff;
   assign acc_r_o  = acc_r_ff;
   assign rem_e_o  = rem_e_ff;
   assign root_e_o = root_e_ff;
   assign rem_s_o  = rem_s_ff;
   assign root_s_o = root_s_ff;

endmodule

[rtl/trajectory_circle_approach_test_core.sv]
// throughput: one item per cycle; the whole pipeline advances unless rsp is stalled
// the row of 2*COORD_BITS+2 cells sets the latency: one multiplier bit per cell
// the first COORD_BITS+1 cells also take one root bit of both squared distances
// synchronous active-high reset empties the pipeline and clears the circle registers
`timescale 1ns / 1ps
module trajectory_circle_approach_test_core #(
   parameter int COORD_BITS = tcat_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [COORD_BITS-1:0]               req_start_x,
   input  logic [COORD_BITS-1:0]               req_start_y,
   input  logic [COORD_BITS-1:0]               req_end_x,
   input  logic [COORD_BITS-1:0]               req_end_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_approaching_hit,
   input  logic                                csr_we,
   input  logic [tcat_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]               csr_wdata
);
   import tcat_pkg::*;

   localparam int XW = 2 * COORD_BITS + 2;
   localparam int AW = 2 * XW;
   localparam int NC = XW;

   logic [COORD_BITS-1:0] center_x_ff, center_y_ff, radius_ff;
   logic                  en;

   tcat_ctl_type  ctl_w   [0:NC];
   logic [XW-1:0] cross_w [0:NC];
   logic [XW-1:0] rr_w    [0:NC];
   logic [XW-1:0] len2_w  [0:NC];
   logic [AW-1:0] acc_c_w [0:NC];
   logic [AW-1:0] acc_r_w [0:NC];
   logic [XW-1:0] rem_e_w [0:NC];
   logic [XW-1:0] root_e_w[0:NC];
   logic [XW-1:0] rem_s_w [0:NC];
   logic [XW-1:0] root_s_w[0:NC];
   logic [XW-1:0] se_w, ss_w;

   logic          rsp_valid_ff, rsp_hit_ff, rsp_hit_in;
   logic [XW:0]   dist_e, dist_s;
   logic          near_line;

   assign en        = rsp_ready || !rsp_valid_ff;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_CENTER_X: center_x_ff <= csr_wdata;
            REG_CENTER_Y: center_y_ff <= csr_wdata;
            REG_RADIUS:   radius_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   tcat_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .start_x  (req_start_x),
      .start_y  (req_start_y),
      .end_x    (req_end_x),
      .end_y    (req_end_y),
      .center_x (center_x_ff),
      .center_y (center_y_ff),
      .radius   (radius_ff),
      .ctl_o    (ctl_w[0]),
      .cross_o  (cross_w[0]),
      .len2_o   (len2_w[0]),
      .rr_o     (rr_w[0]),
      .se_o     (se_w),
      .ss_o     (ss_w)
   );

   // accumulators start at zero, roots start at zero with the squared distance as remainder
   assign acc_c_w[0]  = '0;
   assign acc_r_w[0]  = '0;
   assign rem_e_w[0]  = se_w;
   assign root_e_w[0] = '0;
   assign rem_s_w[0]  = ss_w;
   assign root_s_w[0] = '0;

   generate
      for (genvar i = 0; i < NC; i++) begin : g_cell
         tcat_cell #(.COORD_BITS(COORD_BITS), .IDX(i)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .en       (en),
            .ctl_i    (ctl_w[i]),
            .cross_i  (cross_w[i]),
            .rr_i     (rr_w[i]),
            .len2_i   (len2_w[i]),
            .acc_c_i  (acc_c_w[i]),
            .acc_r_i  (acc_r_w[i]),
            .rem_e_i  (rem_e_w[i]),
            .root_e_i (root_e_w[i]),
            .rem_s_i  (rem_s_w[i]),
            .root_s_i (root_s_w[i]),
            .ctl_o    (ctl_w[i+1]),
            .cross_o  (cross_w[i+1]),
            .rr_o     (rr_w[i+1]),
            .len2_o   (len2_w[i+1]),
            .acc_c_o  (acc_c_w[i+1]),
            .acc_r_o  (acc_r_w[i+1]),
            .rem_e_o  (rem_e_w[i+1]),
            .root_e_o (root_e_w[i+1]),
            .rem_s_o  (rem_s_w[i+1]),
            .root_s_o (root_s_w[i+1])
         );
      end
   endgenerate

   // round up when the remainder exceeds the floor root
   always_comb begin
      dist_e = {1'b0, root_e_w[NC]} + {{XW{1'b0}}, (rem_e_w[NC] > root_e_w[NC])};
      dist_s = {1'b0, root_s_w[NC]} + {{XW{1'b0}}, (rem_s_w[NC] > root_s_w[NC])};
      near_line  = acc_c_w[NC] <= acc_r_w[NC];
      rsp_hit_in = ctl_w[NC].nonzero && near_line && (dist_e < dist_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ctl_w[NC].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_hit_ff <= rsp_hit_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_approaching_hit = rsp_hit_ff;

   a_ready_follows_stall: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not match output stall");

   a_stall_freezes_row: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(ctl_w[NC]))
      else $error("cell row moved during stall");

   a_zero_length_no_hit: assert property (@(posedge clock) disable iff (reset)
      en && ctl_w[NC].valid && !ctl_w[NC].nonzero |=> !rsp_approaching_hit)
      else $error("zero-length item reported a hit");

   a_root_remainder_e: assert property (@(posedge clock) disable iff (reset)
      ctl_w[NC].valid |-> ({1'b0, rem_e_w[NC]} <= {root_e_w[NC], 1'b0}))
      else $error("end distance root remainder out of range");

   a_root_remainder_s: assert property (@(posedge clock) disable iff (reset)
      ctl_w[NC].valid |-> ({1'b0, rem_s_w[NC]} <= {root_s_w[NC], 1'b0}))
      else $error("start distance root remainder out of range");

endmodule

[tb/testbench.sv]
// testbench for the trajectory circle approach test core
`timescale 1ns / 1ps
module testbench;
   import tcat_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam int DRAIN_CYCLES = 2 * CB + 12;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
   localparam logic [CB-1:0] COORD_MIN = {1'b1, {(CB-1){1'b0}}};
   localparam logic [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};
   localparam logic [CB-1:0] RADIUS_MAX = {CB{1'b1}};

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [CB-1:0] req_start_x, req_start_y, req_end_x, req_end_y;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_approaching_hit;
   logic csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CB-1:0] csr_wdata;

   // circle as the block should hold it
   logic [CB-1:0] circle_cx, circle_cy, circle_r;
   bit expected_hits[$];
   int error_count;
   bit gaps_on;
   int hold_request;

   trajectory_circle_approach_test_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_approaching_hit(rsp_approaching_hit),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint coord_value(logic [CB-1:0] v);
      longint r;
      r = $signed(v);
      return r;
   endfunction

   function automatic longint unsigned floor_root(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned round_dist(longint x, longint y);
      longint ax, ay;
      longint unsigned s, k;
      ax = coord_value(circle_cx) - x;
      ay = coord_value(circle_cy) - y;
      s = ax * ax + ay * ay;
      k = floor_root(s);
      if (s >= k * k + k + 1) k = k + 1;
      return k;
   endfunction

   function automatic bit approach_hit(logic [CB-1:0] sxv, syv, exv, eyv);
      longint sx, sy, ex, ey, dx, dy, cr;
      logic [127:0] cross_sq, reach_sq, len_sq, rad;
      sx = coord_value(sxv);
      sy = coord_value(syv);
      ex = coord_value(exv);
      ey = coord_value(eyv);
      dx = ex - sx;
      dy = ey - sy;
      if (dx == 0 && dy == 0) return 1'b0;
      cr = dx * (coord_value(circle_cy) - sy) - dy * (coord_value(circle_cx) - sx);
      if (cr < 0) cr = -cr;
      cross_sq = 128'(cr) * 128'(cr);
      len_sq = 128'(dx * dx) + 128'(dy * dy);
      rad = 128'(circle_r);
      reach_sq = rad * rad * len_sq;
      if (cross_sq > reach_sq) return 1'b0;
      return round_dist(ex, ey) < round_dist(sx, sy);
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
            rsp_ready <= 1'b1;
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (gap_len()) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_hits.size() == 0) begin
            $display("%0t: unexpected item, actual hit %0b", $time, rsp_approaching_hit);
            error_count++;
         end else begin
            if (rsp_approaching_hit !== expected_hits[0]) begin
               $display("%0t: approaching_hit mismatch, expected %0b actual %0b",
                        $time, expected_hits[0], rsp_approaching_hit);
               error_count++;
            end
            void'(expected_hits.pop_front());
         end
      end
   end

   task automatic send_segment(logic [CB-1:0] sx, sy, ex, ey);
      int g;
      expected_hits.push_back(approach_hit(sx, sy, ex, ey));
      req_valid <= 1'b1;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x <= ex;
      req_end_y <= ey;
      do @(posedge clock); while (!req_ready);
      g = (gaps_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // stop offering items, then let everything drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // program the circle, with a write to the unused index that must be ignored
   task automatic set_circle(logic [CB-1:0] cx, cy, r);
      wait_idle();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= REG_CENTER_X;
      csr_wdata <= cx;
      @(posedge clock);
      csr_index <= REG_CENTER_Y;
      csr_wdata <= cy;
      @(posedge clock);
      csr_index <= REG_RADIUS;
      csr_wdata <= r;
      @(posedge clock);
      csr_index <= REG_UNUSED;
      csr_wdata <= CB'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      circle_cx = cx;
      circle_cy = cy;
      circle_r = r;
   endtask

   function automatic logic [CB-1:0] near(logic [CB-1:0] c, int span);
      return c + CB'($urandom_range(0, 2 * span) - span);
   endfunction

   function automatic logic [CB-1:0] any_coord();
      case ($urandom_range(0, 3))
         0: return COORD_MIN;
         1: return COORD_MAX;
         default: return CB'($urandom);
      endcase
   endfunction

   task automatic test_reset_circle();
      send_segment(CB'(-10), CB'(3), CB'(0), CB'(1));
      send_segment(CB'(5), CB'(5), CB'(5), CB'(5));
   endtask

   task automatic test_directed();
      set_circle('0, '0, CB'(5));
      send_segment(CB'(-10), CB'(5), CB'(0), CB'(5));    // tangent line
      send_segment(CB'(-10), CB'(6), CB'(0), CB'(6));    // just outside
      send_segment(CB'(0), CB'(5), CB'(-10), CB'(5));    // moving away
      send_segment(CB'(7), CB'(7), CB'(7), CB'(7));      // zero length
      send_segment(CB'(4), CB'(2), CB'(3), CB'(3));      // same rounded distance
      send_segment(CB'(-3), CB'(-3), CB'(1), CB'(1));
      set_circle(COORD_MIN, COORD_MAX, RADIUS_MAX);
      send_segment(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
      send_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      send_segment(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
      send_segment('0, '0, COORD_MIN, COORD_MAX);
      set_circle(COORD_MAX, COORD_MIN, '0);
      send_segment(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
      send_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN);
      send_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN);
      send_segment(CB'(-1), CB'(-1), CB'(-1), CB'(-1));
   endtask

   task automatic test_random(int phases, int per_phase);
      logic [CB-1:0] cx, cy, r, sx, sy;
      int span;
      for (int p = 0; p < phases; p++) begin
         cx = ($urandom_range(0, 3) == 0) ? any_coord() : CB'($urandom_range(0, 2000) - 1000);
         cy = ($urandom_range(0, 3) == 0) ? any_coord() : CB'($urandom_range(0, 2000) - 1000);
         case ($urandom_range(0, 4))
            0: r = '0;
            1: r = RADIUS_MAX;
            2: r = CB'($urandom);
            default: r = CB'($urandom_range(1, 500));
         endcase
         set_circle(cx, cy, r);
         gaps_on = (p % 3) != 2;
         for (int i = 0; i < per_phase; i++) begin
            span = ($urandom_range(0, 1) == 0) ? 600 : 40000;
            if ($urandom_range(0, 4) == 0) begin
               send_segment(any_coord(), any_coord(), any_coord(), any_coord());
            end else begin
               sx = near(cx, span);
               sy = near(cy, span);
               // mostly heading in toward the center
               send_segment(sx, sy, near(cx, span / 4), near(cy, span / 4));
            end
         end
      end
      gaps_on = 1'b1;
   endtask

   task automatic test_backpressure();
      set_circle('0, '0, CB'(100));
      hold_request = 300;
      for (int i = 0; i < 150; i++)
         send_segment(near('0, 300), near('0, 300), near('0, 60), near('0, 60));
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_start_x = '0;
      req_start_y = '0;
      req_end_x = '0;
      req_end_y = '0;
      csr_we = 1'b0;
      csr_index = REG_CENTER_X;
      csr_wdata = '0;
      circle_cx = '0;
      circle_cy = '0;
      circle_r = '0;
      error_count = 0;
      gaps_on = 1'b1;
      hold_request = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_circle();
      test_directed();
      test_backpressure();
      test_random(6, 215);
      wait_idle();
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end
endmodule

[sim.f]
rtl/tcat_pkg.sv
rtl/tcat_front.sv
rtl/tcat_cell.sv
rtl/trajectory_circle_approach_test_core.sv
tb/testbench.sv
